@@ hdl/cwss_pkg.sv @@
// Package for the comment and whitespace stripper: widths, character codes,
// result record type and small helper functions. No dependencies.
package cwss_pkg;

  localparam int BYTE_W     = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Character codes that steer the stripper.
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CH_SLASH   = 8'd47;
  localparam logic [BYTE_W-1:0] CH_STAR    = 8'd42;

  // Result kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

  // Whitespace other than newline: tab, vertical tab, form feed, return, space.
  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    is_blank = c inside {8'd9, 8'd11, 8'd12, 8'd13, 8'd32};
  endfunction

  // Builds one result record with the last flag cleared.
  function automatic res_t mk_res(input logic kind, input logic [BYTE_W-1:0] c);
    res_t r;
    r.kind = kind;
    r.data = (kind == KIND_EOL) ? '0 : c;
    r.last = 1'b0;
    mk_res = r;
  endfunction

endpackage

@@ hdl/cwss_if.sv @@
// Valid/ready channel interfaces for the stripper's input and result streams.
// Depends on cwss_pkg for the byte width.
interface cwss_in_if;
  import cwss_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface cwss_out_if;
  import cwss_pkg::*;

  logic              valid;
  logic              ready;
  logic              out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_kind, output out_byte, output last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input last,
                  output ready);
endinterface

@@ hdl/comment_whitespace_stripper_core.sv @@
// Top level of the C comment and whitespace stripper.
// Depends on cwss_pkg and the channel interfaces in cwss_if.sv.
//
//   Channel | Direction | Request contents
//   in_ch   | sink      | in_byte, end_of_input
//   out_ch  | source    | out_kind, out_byte, last
//
// Each accepted byte is decoded in the cycle it is accepted and yields zero,
// one or two results, written into a four-entry result queue.
// A byte is taken whenever the queue has two free entries, so one byte per
// cycle flows while each byte yields at most one result and out_ch.ready stays high;
// the queue drains one result per cycle, which sets the rate for bytes that yield two.
// Reset is synchronous and active low; it clears the parser state and queue.
// A stalled result side fills the queue and then holds in_ch.ready low.
module comment_whitespace_stripper_core (
  input logic clk,
  input logic rst_n,
  cwss_in_if.sink    in_ch,
  cwss_out_if.source out_ch
);
  import cwss_pkg::*;

  // Parser state.
  logic inside_block_r, inside_block_nxt;
  logic held_slash_r,   held_slash_nxt;
  logic held_star_r,    held_star_nxt;
  logic inside_line_r,  inside_line_nxt;
  logic line_nonempty_r, line_nonempty_nxt;

  // Result queue.
  res_t              queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  logic       in_fire;
  logic       out_fire;
  logic [1:0] n_res;
  res_t       res0;
  res_t       res1;

  assign in_ch.ready = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  // Decode one byte: next state and up to two results.
  always_comb begin
    logic [BYTE_W-1:0] c;
    logic              fin;
    logic              ib, hs, hst, ilc, ln;
    logic [1:0]        n;
    res_t              r0, r1;

    c   = in_ch.in_byte;
    fin = in_ch.end_of_input;
    ib  = inside_block_r;
    hs  = held_slash_r;
    hst = held_star_r;
    ilc = inside_line_r;
    ln  = line_nonempty_r;
    n   = 2'd0;
    r0  = '0;
    r1  = '0;

    if (c == CH_NEWLINE) begin
      if (hs) begin
        hs = 1'b0;
        if (n == 2'd0) r0 = mk_res(KIND_CHAR, CH_SLASH);
        else if (n == 2'd1) r1 = mk_res(KIND_CHAR, CH_SLASH);
        if (n != 2'd2) n = n + 2'd1;
        ln = 1'b1;
      end
      ilc = 1'b0;
      hst = 1'b0;
      if (ln) begin
        if (n == 2'd0) r0 = mk_res(KIND_EOL, '0);
        else if (n == 2'd1) r1 = mk_res(KIND_EOL, '0);
        if (n != 2'd2) n = n + 2'd1;
      end
      ln = 1'b0;
    end else if (is_blank(c) || ilc) begin
      // Dropped without any change of state.
    end else if (ib) begin
      if (hst && c == CH_SLASH) begin
        ib  = 1'b0;
        hst = 1'b0;
      end else begin
        hst = (c == CH_STAR);
      end
    end else if (hs) begin
      hs = 1'b0;
      if (c == CH_STAR) begin
        ib  = 1'b1;
        hst = 1'b0;
      end else if (c == CH_SLASH) begin
        ilc = 1'b1;
      end else begin
        // Released slash and this byte fill both slots; n is zero here.
        r0 = mk_res(KIND_CHAR, CH_SLASH);
        r1 = mk_res(KIND_CHAR, c);
        n  = 2'd2;
        ln = 1'b1;
      end
    end else if (c == CH_SLASH) begin
      hs = 1'b1;
    end else begin
      r0 = mk_res(KIND_CHAR, c);
      n  = 2'd1;
      ln = 1'b1;
    end

    // End of text: flush a held slash and the final line, then reset.
    if (fin) begin
      if (hs) begin
        if (n == 2'd0) r0 = mk_res(KIND_CHAR, CH_SLASH);
        else if (n == 2'd1) r1 = mk_res(KIND_CHAR, CH_SLASH);
        if (n != 2'd2) n = n + 2'd1;
        ln = 1'b1;
      end
      if (ln) begin
        if (n == 2'd0) r0 = mk_res(KIND_EOL, '0);
        else if (n == 2'd1) r1 = mk_res(KIND_EOL, '0);
        if (n != 2'd2) n = n + 2'd1;
      end
      ib  = 1'b0;
      hs  = 1'b0;
      hst = 1'b0;
      ilc = 1'b0;
      ln  = 1'b0;
    end

    // Mark the final result of this byte.
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;

    n_res             = n;
    res0              = r0;
    res1              = r1;
    inside_block_nxt  = ib;
    held_slash_nxt    = hs;
    held_star_nxt     = hst;
    inside_line_nxt   = ilc;
    line_nonempty_nxt = ln;
  end

  // Queue pointer and count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_res);
      count_nxt  = count_nxt + QCNT_W'(n_res);
    end
    if (out_fire) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
      count_nxt  = count_nxt - QCNT_W'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_block_r  <= 1'b0;
      held_slash_r    <= 1'b0;
      held_star_r     <= 1'b0;
      inside_line_r   <= 1'b0;
      line_nonempty_r <= 1'b0;
      wr_ptr_r        <= '0;
      rd_ptr_r        <= '0;
      count_r         <= '0;
    end else begin
      if (in_fire) begin
        inside_block_r  <= inside_block_nxt;
        held_slash_r    <= held_slash_nxt;
        held_star_r     <= held_star_nxt;
        inside_line_r   <= inside_line_nxt;
        line_nonempty_r <= line_nonempty_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue payload, written at the write pointer and the entry after it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (n_res != 2'd0) queue_r[wr_ptr_r] <= res0;
      if (n_res == 2'd2) queue_r[wr_ptr_r + QPTR_W'(1)] <= res1;
    end
  end

  // Result channel driven from the queue head.
  assign out_ch.valid    = (count_r != '0);
  assign out_ch.out_kind = queue_r[rd_ptr_r].kind;
  assign out_ch.out_byte = queue_r[rd_ptr_r].data;
  assign out_ch.last     = queue_r[rd_ptr_r].last;

  // The queue never holds more entries than it has.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue count exceeds depth");

  // A pending star only exists inside a block comment.
  a_star_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    held_star_r |-> inside_block_r)
    else $error("held star outside block comment");

  // A held slash is never inside any comment.
  a_slash_outside: assert property (@(posedge clk) disable iff (!rst_n)
    held_slash_r |-> (!inside_block_r && !inside_line_r))
    else $error("held slash inside a comment");

  // The last byte of a text returns the parser to its reset state.
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.end_of_input) |=>
      (!inside_block_r && !held_slash_r && !held_star_r &&
       !inside_line_r && !line_nonempty_r))
    else $error("parser state not cleared after end of input");

endmodule

@@ tb/comment_whitespace_stripper_core_test.sv @@
`timescale 1ns / 1ps
// Testbench for comment_whitespace_stripper_core: feeds byte requests over in_ch,
// predicts the stripped stream and checks every out_ch request against it.
// Depends on cwss_pkg, the channel interfaces in cwss_if.sv and the core.
module comment_whitespace_stripper_core_test;
  import cwss_pkg::*;

  // Bytes that the stripper drops as whitespace, newline excluded.
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_VTAB  = 8'd11;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'd12;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

  localparam int RAND_REQS    = 1750;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 500000;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              eoi;
  } byte_req_t;

  logic clk = 1'b0;
  logic rst_n;

  cwss_in_if  in_ch ();
  cwss_out_if out_ch ();

  comment_whitespace_stripper_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Pending byte requests and the stripped results they are expected to yield.
  byte_req_t src_bytes [$];
  res_t      expected_out [$];

  // Predicted parser state.
  logic in_block;
  logic slash_held;
  logic star_held;
  logic in_line_cmt;
  logic line_has_text;

  res_t step_res [2];
  int   step_n;

  int reqs_total    = 0;
  int reqs_accepted = 0;
  int texts_ended   = 0;
  int results_seen  = 0;
  int line_ends     = 0;
  int errors        = 0;
  int cycles        = 0;

  int        send_wait   = 0;
  int        recv_wait   = 0;
  bit        send_steady = 1'b0;
  bit        recv_steady = 1'b0;
  byte_req_t cur_req;
  res_t      exp_res;

  function automatic bit is_space_char(input logic [BYTE_W-1:0] c);
    return c == CH_TAB || c == CH_VTAB || c == CH_FF || c == CH_CR || c == CH_SPACE;
  endfunction

  // At most two results fit in one step; extra ones are dropped.
  function automatic void add_result(input logic kind, input logic [BYTE_W-1:0] c);
    if (step_n < 2) begin
      step_res[step_n].kind = kind;
      step_res[step_n].data = (kind == KIND_EOL) ? '0 : c;
      step_res[step_n].last = 1'b0;
      step_n++;
    end
  endfunction

  function automatic void keep_char(input logic [BYTE_W-1:0] c);
    add_result(KIND_CHAR, c);
    line_has_text = 1'b1;
  endfunction

  // Advances the predicted parser by one byte and queues the results it yields.
  function automatic void strip_byte(input logic [BYTE_W-1:0] c, input logic eoi);
    step_n = 0;
    if (c == CH_NEWLINE) begin
      if (slash_held) begin
        slash_held = 1'b0;
        keep_char(CH_SLASH);
      end
      in_line_cmt = 1'b0;
      star_held   = 1'b0;
      if (line_has_text)
        add_result(KIND_EOL, '0);
      line_has_text = 1'b0;
    end else if (is_space_char(c) || in_line_cmt) begin
      // Dropped without touching the state.
    end else if (in_block) begin
      if (star_held && c == CH_SLASH) begin
        in_block  = 1'b0;
        star_held = 1'b0;
      end else begin
        star_held = (c == CH_STAR);
      end
    end else if (slash_held) begin
      slash_held = 1'b0;
      if (c == CH_STAR) begin
        in_block  = 1'b1;
        star_held = 1'b0;
      end else if (c == CH_SLASH) begin
        in_line_cmt = 1'b1;
      end else begin
        keep_char(CH_SLASH);
        keep_char(c);
      end
    end else if (c == CH_SLASH) begin
      slash_held = 1'b1;
    end else begin
      keep_char(c);
    end

    // End of text flushes a held slash and the open line, then starts afresh.
    if (eoi) begin
      if (slash_held)
        keep_char(CH_SLASH);
      if (line_has_text)
        add_result(KIND_EOL, '0);
      in_block      = 1'b0;
      slash_held    = 1'b0;
      star_held     = 1'b0;
      in_line_cmt   = 1'b0;
      line_has_text = 1'b0;
      texts_ended++;
    end

    if (step_n > 0)
      step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++)
      expected_out.insert(expected_out.size(), step_res[i]);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  function automatic int draw_wait(input bit steady);
    return steady ? 0 : int'($urandom_range(0, 9));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_blank();
    case ($urandom_range(0, 4))
      0: return CH_TAB;
      1: return CH_VTAB;
      2: return CH_FF;
      3: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // Bytes biased toward the ones that steer the parser.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return CH_STAR;
      1: return CH_SLASH;
      2: return CH_NEWLINE;
      3: return pick_blank();
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_req(input logic [BYTE_W-1:0] b, input logic eoi);
    byte_req_t r;
    r.b   = b;
    r.eoi = eoi;
    src_bytes.insert(src_bytes.size(), r);
    reqs_total++;
  endfunction

  function automatic void queue_text(input string s, input bit eoi_at_end);
    for (int i = 0; i < s.len(); i++)
      queue_req(s[i], eoi_at_end && (i == s.len() - 1));
  endfunction

  // Random part: end of text falls on roughly one byte in eighty.
  function automatic void queue_rand_byte(input logic [BYTE_W-1:0] b);
    queue_req(b, $urandom_range(0, 79) == 0);
  endfunction

  function automatic void queue_block_comment(input bit tricky_open);
    queue_rand_byte(CH_SLASH);
    if ($urandom_range(0, 3) == 0)
      queue_rand_byte(pick_blank());
    queue_rand_byte(CH_STAR);
    if (tricky_open)
      queue_rand_byte(CH_SLASH);
    repeat ($urandom_range(0, 6)) queue_rand_byte(pick_byte());
    queue_rand_byte(CH_STAR);
    if ($urandom_range(0, 3) == 0)
      queue_rand_byte(pick_blank());
    queue_rand_byte(CH_SLASH);
  endfunction

  // Request driver: one byte request per handshake, random gaps in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        strip_byte(in_ch.in_byte, in_ch.end_of_input);
        reqs_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_ch.valid <= 1'b0;
        end else if (src_bytes.size() > 0) begin
          cur_req = src_bytes.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.in_byte      <= cur_req.b;
          in_ch.end_of_input <= cur_req.eoi;
          if ($urandom_range(0, 49) == 0)
            send_steady = !send_steady;
          send_wait = draw_wait(send_steady);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted request against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.out_kind == KIND_EOL)
          line_ends++;
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d byte=%0d last=%0d",
                                    out_ch.out_kind, out_ch.out_byte, out_ch.last));
        end else begin
          exp_res = expected_out.pop_front();
          if (out_ch.out_kind !== exp_res.kind)
            report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                      results_seen, out_ch.out_kind, exp_res.kind));
          if (out_ch.out_byte !== exp_res.data)
            report_mismatch($sformatf("result %0d byte %0d, expected %0d",
                                      results_seen, out_ch.out_byte, exp_res.data));
          if (out_ch.last !== exp_res.last)
            report_mismatch($sformatf("result %0d last %0d, expected %0d",
                                      results_seen, out_ch.last, exp_res.last));
        end
        if ($urandom_range(0, 49) == 0)
          recv_steady = !recv_steady;
        recv_wait = draw_wait(recv_steady);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("comment_whitespace_stripper_core_test failed");
      $finish;
    end
  end

  initial begin
    in_block      = 1'b0;
    slash_held    = 1'b0;
    star_held     = 1'b0;
    in_line_cmt   = 1'b0;
    line_has_text = 1'b0;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = '0;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;

    // Line comment opened across a dropped blank, with a star inside it.
    queue_text("q/ /*\n", 1'b0);
    // Slash right after the opener does not close; the block spans a line.
    queue_text("/*/a\n**/", 1'b0);
    // Held slash released by an ordinary last byte.
    queue_text("/b", 1'b1);
    // Unclosed block comment thrown away at end of text.
    queue_text("/*x", 1'b1);
    // Byte extremes, every blank but space, then a held slash flushed at end of text.
    queue_req(8'd0, 1'b0);
    queue_req(8'd255, 1'b0);
    queue_req(CH_TAB, 1'b0);
    queue_req(CH_VTAB, 1'b0);
    queue_req(CH_FF, 1'b0);
    queue_req(CH_CR, 1'b0);
    queue_req(CH_SLASH, 1'b1);

    // Mostly well-formed fragments with random content, plus noise.
    while (reqs_total < RAND_REQS + 25) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 6))
          queue_rand_byte(BYTE_W'($urandom_range(0, 255)));
        3: queue_block_comment(1'b0);
        4: begin
          queue_rand_byte(CH_SLASH);
          queue_rand_byte(CH_SLASH);
          repeat ($urandom_range(0, 6)) queue_rand_byte(pick_byte());
          queue_rand_byte(CH_NEWLINE);
        end
        5: queue_rand_byte(CH_NEWLINE);
        6: repeat ($urandom_range(1, 3)) queue_rand_byte(pick_blank());
        7: begin
          queue_rand_byte(CH_SLASH);
          queue_rand_byte(pick_byte());
        end
        8: repeat ($urandom_range(1, 4)) queue_rand_byte(pick_byte());
        default: queue_block_comment(1'b1);
      endcase
    end
    // Close the last text so its final line is flushed.
    queue_req(CH_SPACE, 1'b1);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_accepted < reqs_total) @(posedge clk);
    while (expected_out.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_out.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", expected_out.size()));

    $display("Sent %0d byte requests in %0d texts; checked %0d results, %0d of them line ends.",
             reqs_accepted, texts_ended, results_seen, line_ends);
    $display("Mismatches: %0d, cycles: %0d.", errors, cycles);
    if (errors == 0)
      $display("comment_whitespace_stripper_core_test passed");
    else
      $display("comment_whitespace_stripper_core_test failed");
    $finish;
  end

endmodule
